// ===== hdl/idm_pkg.sv =====
// idm_pkg: register indexes, reset values and caps of the car-following step
// used by idm_car_following_step; no dependencies
package idm_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_MAX_ACCEL     = 3'd0;
    localparam logic [2:0] REG_COMFORT_DECEL = 3'd1;
    localparam logic [2:0] REG_MIN_GAP       = 3'd2;
    localparam logic [2:0] REG_TIME_HEADWAY  = 3'd3;
    localparam logic [2:0] REG_MIN_SPACING   = 3'd4;

    // register reset values
    localparam logic [15:0] RST_MAX_ACCEL     = 16'd256;
    localparam logic [15:0] RST_COMFORT_DECEL = 16'd384;
    localparam logic [15:0] RST_MIN_GAP       = 16'd512;
    localparam logic [15:0] RST_TIME_HEADWAY  = 16'd256;
    localparam logic [15:0] RST_MIN_SPACING   = 16'd26;

    // 2*floor(sqrt(256*384)) for the reset registers
    localparam logic [16:0] RST_SQRT_TERM = 17'd626;

    // clip points of the speed ratio and the interaction ratio, Q16
    localparam logic [39:0] RATIO_CAP = 40'd1048576;
    localparam logic [24:0] INTER_CAP = 25'd16777216;

    localparam logic [15:0] VEL_MAX = 16'hFFFF;
    localparam logic [23:0] POS_MAX = 24'hFF_FFFF;

endpackage

// ===== hdl/idm_car_following_step.sv =====
// idm_car_following_step: pipelined intelligent driver model step for one car
// depends on idm_pkg and idm_div_pipe
//
// One car enters per cycle while s_tready is high: an input
// register, a setup stage, a 40-stage divider pair (speed ratio and the
// closing-speed term, side by side), two stages that form and range-check the
// interaction numerator, a 25-stage divider for the interaction ratio, and six
// stages of squaring, scaling and saturation ending in the output register.
// A stall at the output freezes the whole pipeline in place. Writing
// max_accel or comfort_decel starts a bit-serial square root of their product
// (a start step plus 16 iterations); s_tready stays low while it runs.
// The configuration port is always ready.
module idm_car_following_step (
    input  logic         clk,
    input  logic         rst_n,
    // input car transaction
    input  logic         s_tvalid,
    output logic         s_tready,
    // own_velocity, own_position, leader_velocity, leader_position,
    // leader_length, speed_limit, desired_speed
    input  logic [127:0] s_tdata,
    // has_leader
    input  logic [0:0]   s_tuser,
    // result transaction
    output logic         m_tvalid,
    input  logic         m_tready,
    // acceleration, new_velocity, new_position, saturated, zero pad
    output logic [63:0]  m_tdata,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    typedef struct packed {
        logic [15:0] v;
        logic [23:0] op;
        logic        lead;
        logic [15:0] lv;
        logic [23:0] lp;
        logic [15:0] ll;
        logic [15:0] lim;
        logic [15:0] des;
    } in_t;

    typedef struct packed {
        logic [15:0] eff;
        logic [31:0] pv;
        logic        neg;
        logic [31:0] vth;
        logic [23:0] gap;
        logic        lead;
        logic [15:0] v;
        logic [23:0] op;
        logic [16:0] d;
    } s2_t;

    typedef struct packed {
        logic        neg;
        logic [31:0] vth;
        logic [23:0] gap;
        logic        lead;
        logic [23:0] op;
    } sba_t;

    typedef struct packed {
        logic [20:0]        r;
        logic               rsat;
        logic signed [41:0] num;
        logic [23:0]        gap;
        logic               lead;
        logic [23:0]        op;
        logic [15:0]        v;
    } s3_t;

    typedef struct packed {
        logic        ovf;
        logic [20:0] r;
        logic        rsat;
        logic        lead;
        logic [23:0] op;
        logic [15:0] v;
    } sbb_t;

    typedef struct packed {
        logic [24:0] dnum;
        logic [23:0] drem;
        logic [23:0] gap;
        sbb_t        sb;
    } s4_t;

    typedef struct packed {
        logic [24:0] aq;
        logic [24:0] r2;
        logic        sat;
        logic        lead;
        logic [23:0] op;
        logic [15:0] v;
    } m1_t;

    typedef struct packed {
        logic [32:0] r4;
        logic [32:0] inter;
        logic        sat;
        logic [23:0] op;
        logic [15:0] v;
    } m2_t;

    typedef struct packed {
        logic signed [34:0] diff;
        logic               sat;
        logic [23:0]        op;
        logic [15:0]        v;
    } m3_t;

    typedef struct packed {
        logic signed [51:0] prod;
        logic               sat;
        logic [23:0]        op;
        logic [15:0]        v;
    } m4_t;

    typedef struct packed {
        logic [15:0] acc;
        logic [15:0] nv;
        logic        sat;
        logic [23:0] op;
    } m5_t;

    // configuration registers and the derived 2*sqrt(a*b) term
    logic [15:0] max_accel_reg;
    logic [15:0] comfort_decel_reg;
    logic [15:0] min_gap_reg;
    logic [15:0] time_headway_reg;
    logic [15:0] min_spacing_reg;
    logic [16:0] d_reg;

    // square root sequencer
    logic        sq_kick;
    logic        sq_start_reg;
    logic        sq_busy_reg;
    logic [3:0]  sq_cnt_reg;
    logic [31:0] sq_x_reg;
    logic [31:0] sq_res_reg;
    logic [31:0] sq_bit_reg;
    logic [31:0] sq_sum;
    logic        sq_ge;
    logic [31:0] sq_x_next;
    logic [31:0] sq_res_next;
    logic [16:0] sq_d_next;

    // pipeline
    logic en;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg, m5_vld_reg, out_vld_reg;
    in_t  s1_reg;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    m1_t  m1_reg, m1_next;
    m2_t  m2_reg, m2_next;
    m3_t  m3_reg, m3_next;
    m4_t  m4_reg, m4_next;
    m5_t  m5_reg, m5_next;
    logic [15:0] acc_out_reg, acc_out_next;
    logic [15:0] nv_out_reg, nv_out_next;
    logic [23:0] np_out_reg, np_out_next;
    logic        sat_out_reg, sat_out_next;

    logic        ra_vld, da_vld, d3_vld;
    logic [39:0] ra_quo, da_quo;
    logic [24:0] d3_quo;
    logic [15:0] ra_v;
    sba_t        da_sb;
    sbb_t        d3_sb;
    sba_t        sba_in;
    sbb_t        d3_sb_unused_guard;

    // the whole pipeline moves unless a result waits at the output
    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en && !sq_busy_reg && !sq_start_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {7'd0, sat_out_reg, np_out_reg, nv_out_reg, acc_out_reg};

    // a write to either operand of the root restarts it
    assign sq_kick = cfg_valid && cfg_ready
                     && (cfg_index == idm_pkg::REG_MAX_ACCEL
                         || cfg_index == idm_pkg::REG_COMFORT_DECEL);

    // ---------------------------------------------------------------------
    // configuration and square root of max_accel*comfort_decel
    // ---------------------------------------------------------------------
    always_comb
    begin
        sq_sum      = sq_res_reg + sq_bit_reg;
        sq_ge       = sq_x_reg >= sq_sum;
        sq_x_next   = sq_ge ? (sq_x_reg - sq_sum) : sq_x_reg;
        sq_res_next = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
        // a zero product would give a zero divisor, used as one
        sq_d_next   = {sq_res_next[15:0], 1'b0};
        if (sq_d_next == 17'd0)
        begin
            sq_d_next = 17'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accel_reg     <= idm_pkg::RST_MAX_ACCEL;
            comfort_decel_reg <= idm_pkg::RST_COMFORT_DECEL;
            min_gap_reg       <= idm_pkg::RST_MIN_GAP;
            time_headway_reg  <= idm_pkg::RST_TIME_HEADWAY;
            min_spacing_reg   <= idm_pkg::RST_MIN_SPACING;
            d_reg             <= idm_pkg::RST_SQRT_TERM;
            sq_start_reg      <= 1'b0;
            sq_busy_reg       <= 1'b0;
            sq_cnt_reg        <= 4'd0;
            sq_x_reg          <= 32'd0;
            sq_res_reg        <= 32'd0;
            sq_bit_reg        <= 32'd0;
        end
        else
        begin
            sq_start_reg <= sq_kick;
            if (sq_start_reg)
            begin
                // operands are settled, load the product and run 16 steps
                sq_busy_reg  <= 1'b1;
                sq_cnt_reg   <= 4'd0;
                sq_x_reg     <= max_accel_reg * comfort_decel_reg;
                sq_res_reg   <= 32'd0;
                sq_bit_reg   <= 32'h4000_0000;
            end
            else if (sq_busy_reg)
            begin
                sq_x_reg   <= sq_x_next;
                sq_res_reg <= sq_res_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 4'd1;
                if (sq_cnt_reg == 4'd15)
                begin
                    sq_busy_reg <= 1'b0;
                    d_reg       <= sq_d_next;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    idm_pkg::REG_MAX_ACCEL:     max_accel_reg     <= cfg_data;
                    idm_pkg::REG_COMFORT_DECEL: comfort_decel_reg <= cfg_data;
                    idm_pkg::REG_MIN_GAP:       min_gap_reg       <= cfg_data;
                    idm_pkg::REG_TIME_HEADWAY:  time_headway_reg  <= cfg_data;
                    idm_pkg::REG_MIN_SPACING:   min_spacing_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // setup stage: speed bound, clamped gap, closing-speed and headway products
    // ---------------------------------------------------------------------
    always_comb
    begin
        logic [15:0]        ms;
        logic signed [25:0] g;
        logic [15:0]        dv_mag;

        s2_next.eff = (s1_reg.lim < s1_reg.des) ? s1_reg.lim : s1_reg.des;
        if (s2_next.eff == 16'd0)
        begin
            s2_next.eff = 16'd1;
        end
        ms = (min_spacing_reg == 16'd0) ? 16'd1 : min_spacing_reg;
        g  = $signed({2'b00, s1_reg.lp}) - $signed({2'b00, s1_reg.op})
             - $signed({10'd0, s1_reg.ll});
        s2_next.gap  = (g < $signed({10'd0, ms})) ? {8'd0, ms} : g[23:0];
        s2_next.neg  = s1_reg.v < s1_reg.lv;
        dv_mag       = s2_next.neg ? (s1_reg.lv - s1_reg.v) : (s1_reg.v - s1_reg.lv);
        s2_next.pv   = s1_reg.v * dv_mag;
        s2_next.vth  = s1_reg.v * time_headway_reg;
        s2_next.lead = s1_reg.lead;
        s2_next.v    = s1_reg.v;
        s2_next.op   = s1_reg.op;
        s2_next.d    = d_reg;
    end

    assign sba_in.neg  = s2_reg.neg;
    assign sba_in.vth  = s2_reg.vth;
    assign sba_in.gap  = s2_reg.gap;
    assign sba_in.lead = s2_reg.lead;
    assign sba_in.op   = s2_reg.op;

    // speed ratio v*2^16/eff
    idm_div_pipe #(
        .NUM_W (40),
        .DEN_W (17),
        .SB_W  (16)
    ) u_div_ratio (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s2_vld_reg),
        .in_num  ({8'd0, s2_reg.v, 16'd0}),
        .in_rem  (17'd0),
        .in_den  ({1'b0, s2_reg.eff}),
        .in_sb   (s2_reg.v),
        .out_vld (ra_vld),
        .out_quo (ra_quo),
        .out_sb  (ra_v)
    );

    // closing-speed term |v*dv|*256/D
    idm_div_pipe #(
        .NUM_W (40),
        .DEN_W (17),
        .SB_W  ($bits(sba_t))
    ) u_div_close (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s2_vld_reg),
        .in_num  ({s2_reg.pv, 8'd0}),
        .in_rem  (17'd0),
        .in_den  (s2_reg.d),
        .in_sb   (sba_in),
        .out_vld (da_vld),
        .out_quo (da_quo),
        .out_sb  (da_sb)
    );

    // ---------------------------------------------------------------------
    // numerator and ratio clip
    // ---------------------------------------------------------------------
    always_comb
    begin
        logic signed [41:0] t;

        t = da_sb.neg ? -$signed({2'b00, da_quo}) : $signed({2'b00, da_quo});
        s3_next.num  = $signed({18'd0, min_gap_reg, 8'd0}) + $signed({10'd0, da_sb.vth}) + t;
        s3_next.rsat = ra_quo > idm_pkg::RATIO_CAP;
        s3_next.r    = s3_next.rsat ? idm_pkg::RATIO_CAP[20:0] : ra_quo[20:0];
        s3_next.gap  = da_sb.gap;
        s3_next.lead = da_sb.lead;
        s3_next.op   = da_sb.op;
        s3_next.v    = ra_v;
    end

    // ---------------------------------------------------------------------
    // interaction overflow check: |num|*256 >= (2^24+1)*gap means q above cap
    // ---------------------------------------------------------------------
    always_comb
    begin
        logic signed [41:0] a;
        logic [48:0]        mag256;
        logic [48:0]        thr;

        a      = (s3_reg.num < 0) ? -s3_reg.num : s3_reg.num;
        mag256 = {a[40:0], 8'd0};
        thr    = {1'b0, s3_reg.gap, 24'd0} + {25'd0, s3_reg.gap};
        s4_next.sb.ovf  = mag256 >= thr;
        s4_next.sb.r    = s3_reg.r;
        s4_next.sb.rsat = s3_reg.rsat;
        s4_next.sb.lead = s3_reg.lead;
        s4_next.sb.op   = s3_reg.op;
        s4_next.sb.v    = s3_reg.v;
        // without overflow the quotient fits 25 bits, so the top part is the start remainder
        s4_next.dnum    = mag256[24:0];
        s4_next.drem    = mag256[48:25];
        s4_next.gap     = s3_reg.gap;
    end

    idm_div_pipe #(
        .NUM_W (25),
        .DEN_W (24),
        .SB_W  ($bits(sbb_t))
    ) u_div_inter (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s4_vld_reg),
        .in_num  (s4_reg.dnum),
        .in_rem  (s4_reg.drem),
        .in_den  (s4_reg.gap),
        .in_sb   (s4_reg.sb),
        .out_vld (d3_vld),
        .out_quo (d3_quo),
        .out_sb  (d3_sb)
    );

    assign d3_sb_unused_guard = d3_sb;

    // ---------------------------------------------------------------------
    // squares, difference, scale, saturation
    // ---------------------------------------------------------------------
    always_comb
    begin
        logic [41:0] rr;

        rr          = d3_sb_unused_guard.r * d3_sb_unused_guard.r;
        m1_next.r2  = rr[40:16];
        m1_next.aq  = d3_sb_unused_guard.ovf ? idm_pkg::INTER_CAP : d3_quo;
        m1_next.sat = d3_sb_unused_guard.rsat
                      || (d3_sb_unused_guard.lead && d3_sb_unused_guard.ovf);
        m1_next.lead = d3_sb_unused_guard.lead;
        m1_next.op   = d3_sb_unused_guard.op;
        m1_next.v    = d3_sb_unused_guard.v;
    end

    always_comb
    begin
        logic [49:0] r22;
        logic [49:0] qq;

        r22           = m1_reg.r2 * m1_reg.r2;
        qq            = m1_reg.aq * m1_reg.aq;
        m2_next.r4    = r22[48:16];
        m2_next.inter = m1_reg.lead ? qq[48:16] : 33'd0;
        m2_next.sat   = m1_reg.sat;
        m2_next.op    = m1_reg.op;
        m2_next.v     = m1_reg.v;
    end

    always_comb
    begin
        m3_next.diff = $signed(35'd65536) - $signed({2'b00, m2_reg.r4})
                       - $signed({2'b00, m2_reg.inter});
        m3_next.sat  = m2_reg.sat;
        m3_next.op   = m2_reg.op;
        m3_next.v    = m2_reg.v;
    end

    always_comb
    begin
        m4_next.prod = $signed({1'b0, max_accel_reg}) * m3_reg.diff;
        m4_next.sat  = m3_reg.sat;
        m4_next.op   = m3_reg.op;
        m4_next.v    = m3_reg.v;
    end

    always_comb
    begin
        logic signed [35:0] accw;
        logic signed [15:0] acc16;
        logic               acc_sat;
        logic signed [17:0] nvw;
        logic               nv_sat;

        // arithmetic shift is the floor of the division by 2^16
        accw    = m4_reg.prod[51:16];
        acc_sat = 1'b0;
        if (accw > $signed(36'sd32767))
        begin
            acc16   = 16'sh7FFF;
            acc_sat = 1'b1;
        end
        else if (accw < $signed(-36'sd32768))
        begin
            acc16   = -16'sh8000;
            acc_sat = 1'b1;
        end
        else
        begin
            acc16 = accw[15:0];
        end

        nvw    = $signed({2'b00, m4_reg.v}) + $signed({{2{acc16[15]}}, acc16});
        nv_sat = 1'b0;
        // negative speed floors at zero without a clip flag
        if (nvw < 0)
        begin
            m5_next.nv = 16'd0;
        end
        else if (nvw > $signed({2'b00, idm_pkg::VEL_MAX}))
        begin
            m5_next.nv = idm_pkg::VEL_MAX;
            nv_sat     = 1'b1;
        end
        else
        begin
            m5_next.nv = nvw[15:0];
        end
        m5_next.acc = acc16;
        m5_next.sat = m4_reg.sat || acc_sat || nv_sat;
        m5_next.op  = m4_reg.op;
    end

    always_comb
    begin
        logic [24:0] np;

        np           = {1'b0, m5_reg.op} + {9'd0, m5_reg.nv};
        acc_out_next = m5_reg.acc;
        nv_out_next  = m5_reg.nv;
        np_out_next  = np[24] ? idm_pkg::POS_MAX : np[23:0];
        sat_out_next = m5_reg.sat || np[24];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            m4_vld_reg  <= 1'b0;
            m5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_tvalid && s_tready;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= da_vld;
            s4_vld_reg  <= s3_vld_reg;
            m1_vld_reg  <= d3_vld;
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m2_vld_reg;
            m4_vld_reg  <= m3_vld_reg;
            m5_vld_reg  <= m4_vld_reg;
            out_vld_reg <= m5_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.v    <= s_tdata[15:0];
            s1_reg.op   <= s_tdata[39:16];
            s1_reg.lv   <= s_tdata[55:40];
            s1_reg.lp   <= s_tdata[79:56];
            s1_reg.ll   <= s_tdata[95:80];
            s1_reg.lim  <= s_tdata[111:96];
            s1_reg.des  <= s_tdata[127:112];
            s1_reg.lead <= s_tuser[0];
            s2_reg      <= s2_next;
            s3_reg      <= s3_next;
            s4_reg      <= s4_next;
            m1_reg      <= m1_next;
            m2_reg      <= m2_next;
            m3_reg      <= m3_next;
            m4_reg      <= m4_next;
            m5_reg      <= m5_next;
            acc_out_reg <= acc_out_next;
            nv_out_reg  <= nv_out_next;
            np_out_reg  <= np_out_next;
            sat_out_reg <= sat_out_next;
        end
    end

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // the square root term never becomes a zero divisor
    a_d_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        d_reg != 17'd0)
        else $error("sqrt term is zero");

    // the two parallel dividers stay in lockstep
    a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ra_vld == da_vld)
        else $error("ratio and closing-speed dividers out of step");

    // interaction ratio never exceeds its clip after the divider
    a_inter_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m1_vld_reg |-> (m1_reg.aq <= idm_pkg::INTER_CAP))
        else $error("interaction ratio above cap");

endmodule

// ===== hdl/idm_div_pipe.sv =====
// idm_div_pipe: pipelined restoring divider, one quotient bit per stage
// standalone; the caller supplies a start remainder below the divisor
module idm_div_pipe #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 17,
    parameter int SB_W  = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_rem,
    input  logic [DEN_W-1:0] in_den,
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_vld,
    output logic [NUM_W-1:0] out_quo,
    output logic [SB_W-1:0]  out_sb
);

    logic             vld_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [SB_W-1:0]  sb_reg  [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_stage
            logic             vld_src;
            logic [DEN_W-1:0] rem_src;
            logic [NUM_W-1:0] num_src;
            logic [DEN_W-1:0] den_src;
            logic [SB_W-1:0]  sb_src;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             ge;
            logic [NUM_W:0]   shifted;

            if (k == 0)
            begin : g_first
                assign vld_src = in_vld;
                assign rem_src = in_rem;
                assign num_src = in_num;
                assign den_src = in_den;
                assign sb_src  = in_sb;
            end
            else
            begin : g_next
                assign vld_src = vld_reg[k-1];
                assign rem_src = rem_reg[k-1];
                assign num_src = num_reg[k-1];
                assign den_src = den_reg[k-1];
                assign sb_src  = sb_reg[k-1];
            end

            // bring down the next dividend bit, quotient bit shifts in at the bottom
            assign trial   = {rem_src, num_src[NUM_W-1]};
            assign diff    = trial - {1'b0, den_src};
            assign ge      = trial >= {1'b0, den_src};
            assign shifted = {num_src, ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    num_reg[k] <= shifted[NUM_W-1:0];
                    den_reg[k] <= den_src;
                    sb_reg[k]  <= sb_src;
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[NUM_W-1];
    assign out_quo = num_reg[NUM_W-1];
    assign out_sb  = sb_reg[NUM_W-1];

endmodule
